FILE: sv/lcd_pkg.sv
// ----------------------------------------------------------------------------
// LZW code decoder package
// Sizes, the dictionary entry layout, item kinds and the controller states
// shared by the decoder and its testbench.
// ----------------------------------------------------------------------------
package lcd_pkg;

   localparam int FIRST_CODE = 256;
   localparam int LAST_CODE  = 317;
   localparam int MAX_STRING = 64;

   localparam int CODE_W = 9;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 7;

   localparam int DICT_DEPTH  = LAST_CODE - FIRST_CODE + 1;
   localparam int DICT_AW     = $clog2(DICT_DEPTH);
   localparam int STACK_DEPTH = MAX_STRING;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);

   localparam logic KIND_DECODE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   typedef struct packed {
      logic [CODE_W-1:0] prefix;
      logic [BYTE_W-1:0] tail_byte;
      logic [BYTE_W-1:0] first_byte;
      logic [LEN_W-1:0]  length;
   } dict_entry_type;

   localparam int ENTRY_W = $bits(dict_entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_LOOKUP,
      ST_WALK,
      ST_EMIT
   } state_type;

   function automatic logic [DICT_AW-1:0] dict_addr(input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] diff;
      diff = code - CODE_W'(FIRST_CODE);
      return diff[DICT_AW-1:0];
   endfunction

endpackage

FILE: sv/lzw_code_decoder.sv
// ----------------------------------------------------------------------------
// LZW code decoder
// Expands one LZW code per item into the bytes of its string, one result
// item per byte, and maintains the dictionary as codes arrive.
// ----------------------------------------------------------------------------
// A decode item is accepted and looked up, then its prefix chain is walked
// link by link, then its bytes are delivered one by one while the result side
// does not stall, at most 64 bytes being delivered. The walk is paced by the
// single read port of the dictionary memory, the delivery by the read port of
// the unwind stack memory.
// A clear item, or an undefined code with no previous string, gives one
// result item that carries no byte.
module lzw_code_decoder
   import lcd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_kind,
   input  logic [CODE_W-1:0] req_code,
   input  logic              req_block_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_run_last,
   output logic              rsp_bad_code
);

   state_type state_ff, state_in;

   logic [CODE_W-1:0] next_free_ff, next_free_in;
   logic [CODE_W-1:0] prev_code_ff, prev_code_in;
   logic              prev_present_ff, prev_present_in;
   logic              prev_has_tail_ff, prev_has_tail_in;
   logic [BYTE_W-1:0] prev_tail_ff, prev_tail_in;
   logic [BYTE_W-1:0] prev_first_ff, prev_first_in;
   logic [LEN_W-1:0]  prev_len_ff, prev_len_in;

   logic [CODE_W-1:0] head_ff, head_in;
   logic              undef_ff, undef_in;
   logic              last_blk_ff, last_blk_in;
   logic              bad_ff, bad_in;
   logic [CODE_W-1:0] cur_ff, cur_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  hlen_ff, hlen_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic              ext_tail_ff, ext_tail_in;
   logic [BYTE_W-1:0] tail_ff, tail_in;
   logic [BYTE_W-1:0] fbyte_ff, fbyte_in;
   logic [LEN_W-1:0]  k_ff, k_in;
   logic              pend_ff, pend_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_bv_ff, rsp_bv_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_bad_ff, rsp_bad_in;

   logic                 dict_wr_en;
   logic [DICT_AW-1:0]   dict_wr_addr;
   dict_entry_type       dict_wr_data;
   logic [DICT_AW-1:0]   dict_rd_addr;
   dict_entry_type       dict_rd;
   logic                 stk_wr_en;
   logic [STACK_AW-1:0]  stk_wr_addr;
   logic [BYTE_W-1:0]    stk_wr_data;
   logic [STACK_AW-1:0]  stk_rd_addr;
   logic [BYTE_W-1:0]    stk_rd_data;

   logic              req_take;
   logic              out_free;
   logic              code_defined;
   logic [CODE_W-1:0] head_sel;
   logic              head_lit;
   logic              cur_lit;
   logic [LEN_W-1:0]  look_len;
   logic [BYTE_W-1:0] look_first;
   logic [LEN_W-1:0]  look_total;
   logic              reg_ok;
   logic [LEN_W-1:0]  emit_idx;
   logic              emit_last;
   logic [BYTE_W-1:0] emit_byte;

   lcd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DICT_DEPTH)
   ) u_dict (
      .clock   (clock),
      .wr_en   (dict_wr_en),
      .wr_addr (dict_wr_addr),
      .wr_data (dict_wr_data),
      .rd_addr (dict_rd_addr),
      .rd_data (dict_rd)
   );

   lcd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign code_defined = (req_code < next_free_ff);
   assign head_sel     = code_defined ? req_code : prev_code_ff;
   assign head_lit     = (head_ff < CODE_W'(FIRST_CODE));
   assign cur_lit      = (cur_ff < CODE_W'(FIRST_CODE));

   assign look_len   = head_lit ? LEN_W'(1) : dict_rd.length;
   assign look_first = head_lit ? head_ff[BYTE_W-1:0] : dict_rd.first_byte;
   assign look_total = look_len
                     + (undef_ff ? (prev_has_tail_ff ? LEN_W'(2) : LEN_W'(1)) : LEN_W'(0));
   assign reg_ok     = prev_present_ff && !prev_has_tail_ff
                     && (next_free_ff <= CODE_W'(LAST_CODE));

   assign emit_idx  = k_ff - LEN_W'(1);
   assign emit_last = (emit_idx == cnt_ff - LEN_W'(1));
   assign emit_byte = (emit_idx < hlen_ff) ? stk_rd_data
                    : ((emit_idx == hlen_ff) && ext_tail_ff) ? tail_ff : fbyte_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_CLEAR) begin
                  state_in = ST_SINGLE;
               end else if (code_defined || prev_present_ff) begin
                  state_in = ST_LOOKUP;
               end else begin
                  state_in = ST_SINGLE;
               end
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (cur_lit) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && pend_ff && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      next_free_in     = next_free_ff;
      prev_code_in     = prev_code_ff;
      prev_present_in  = prev_present_ff;
      prev_has_tail_in = prev_has_tail_ff;
      prev_tail_in     = prev_tail_ff;
      prev_first_in    = prev_first_ff;
      prev_len_in      = prev_len_ff;
      head_in          = head_ff;
      undef_in         = undef_ff;
      last_blk_in      = last_blk_ff;
      bad_in           = bad_ff;
      cur_in           = cur_ff;
      pos_in           = pos_ff;
      hlen_in          = hlen_ff;
      cnt_in           = cnt_ff;
      ext_tail_in      = ext_tail_ff;
      tail_in          = tail_ff;
      fbyte_in         = fbyte_ff;
      k_in             = k_ff;
      pend_in          = pend_ff;
      rsp_byte_in      = rsp_byte_ff;
      rsp_bv_in        = rsp_bv_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_bad_in       = rsp_bad_ff;
      rsp_valid_in     = rsp_stall ? rsp_valid_ff : 1'b0;

      dict_wr_en   = 1'b0;
      dict_wr_addr = dict_addr(next_free_ff);
      dict_wr_data = '{prefix: prev_code_ff, tail_byte: look_first,
                       first_byte: prev_first_ff, length: prev_len_ff + LEN_W'(1)};
      dict_rd_addr = dict_addr(head_sel);
      stk_wr_en    = 1'b0;
      stk_wr_addr  = pos_ff[STACK_AW-1:0];
      stk_wr_data  = cur_lit ? cur_ff[BYTE_W-1:0] : dict_rd.tail_byte;
      stk_rd_addr  = out_free ? k_ff[STACK_AW-1:0] : emit_idx[STACK_AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               head_in     = head_sel;
               undef_in    = !code_defined;
               last_blk_in = req_block_last;
               if (req_kind == KIND_CLEAR) begin
                  bad_in           = 1'b0;
                  next_free_in     = CODE_W'(FIRST_CODE);
                  prev_code_in     = '0;
                  prev_present_in  = 1'b0;
                  prev_has_tail_in = 1'b0;
                  prev_tail_in     = '0;
               end else if (!code_defined && !prev_present_ff) begin
                  bad_in = 1'b1;
                  if (req_block_last) begin
                     prev_has_tail_in = 1'b0;
                     prev_tail_in     = '0;
                  end
               end
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = '0;
               rsp_bv_in    = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_bad_in   = bad_ff;
            end
         end
         ST_LOOKUP: begin
            dict_rd_addr = dict_addr(head_ff);
            cur_in       = head_ff;
            pos_in       = look_len - LEN_W'(1);
            hlen_in      = look_len;
            cnt_in       = (look_total > LEN_W'(MAX_STRING)) ? LEN_W'(MAX_STRING) : look_total;
            ext_tail_in  = undef_ff && prev_has_tail_ff;
            tail_in      = prev_tail_ff;
            fbyte_in     = look_first;
            if (reg_ok) begin
               dict_wr_en   = 1'b1;
               next_free_in = next_free_ff + CODE_W'(1);
            end
            if (!undef_ff) begin
               prev_code_in     = head_ff;
               prev_present_in  = 1'b1;
               prev_has_tail_in = 1'b0;
               prev_tail_in     = '0;
               prev_first_in    = look_first;
               prev_len_in      = look_len;
            end else if (reg_ok) begin
               prev_code_in     = next_free_ff;
               prev_has_tail_in = 1'b0;
               prev_tail_in     = '0;
               prev_len_in      = prev_len_ff + LEN_W'(1);
            end else if (!prev_has_tail_ff) begin
               prev_has_tail_in = 1'b1;
               prev_tail_in     = look_first;
            end
            if (last_blk_ff) begin
               prev_present_in  = 1'b0;
               prev_has_tail_in = 1'b0;
               prev_tail_in     = '0;
            end
         end
         ST_WALK: begin
            dict_rd_addr = dict_addr(dict_rd.prefix);
            stk_wr_en    = !pos_ff[LEN_W-1];
            if (cur_lit) begin
               k_in    = '0;
               pend_in = 1'b0;
            end else begin
               cur_in = dict_rd.prefix;
               pos_in = pos_ff - LEN_W'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               if (pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = emit_byte;
                  rsp_bv_in    = 1'b1;
                  rsp_last_in  = emit_last;
                  rsp_bad_in   = 1'b0;
               end
               if (k_ff < cnt_ff) begin
                  k_in    = k_ff + LEN_W'(1);
                  pend_in = 1'b1;
               end else begin
                  pend_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         next_free_ff     <= CODE_W'(FIRST_CODE);
         prev_code_ff     <= '0;
         prev_present_ff  <= 1'b0;
         prev_has_tail_ff <= 1'b0;
         prev_tail_ff     <= '0;
         pend_ff          <= 1'b0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         next_free_ff     <= next_free_in;
         prev_code_ff     <= prev_code_in;
         prev_present_ff  <= prev_present_in;
         prev_has_tail_ff <= prev_has_tail_in;
         prev_tail_ff     <= prev_tail_in;
         pend_ff          <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_first_ff <= prev_first_in;
      prev_len_ff   <= prev_len_in;
      head_ff       <= head_in;
      undef_ff      <= undef_in;
      last_blk_ff   <= last_blk_in;
      bad_ff        <= bad_in;
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      hlen_ff       <= hlen_in;
      cnt_ff        <= cnt_in;
      ext_tail_ff   <= ext_tail_in;
      tail_ff       <= tail_in;
      fbyte_ff      <= fbyte_in;
      k_ff          <= k_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bv_ff     <= rsp_bv_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bv_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_bad_code   = rsp_bad_ff;

endmodule

FILE: sv/lcd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module lcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// LZW code decoder testbench
// Drives directed and random code items into the decoder with random gaps
// on both channels. A behavioural copy of the dictionary predicts the bytes
// of every accepted item, and each result item is checked field by field.
// ----------------------------------------------------------------------------
module tb;
   import lcd_pkg::*;

   localparam int IDLE_PERCENT   = 27;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 150;
   localparam int PRINT_LIMIT    = 200;

   typedef struct packed {
      logic              kind;
      logic [CODE_W-1:0] code;
      logic              blk_last;
   } code_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              byte_ok;
      logic              run_end;
      logic              bad;
   } byte_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_kind = KIND_DECODE;
   logic [CODE_W-1:0] req_code = '0;
   logic              req_block_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_byte_valid;
   logic              rsp_run_last;
   logic              rsp_bad_code;

   code_item_type     pending_codes[$];
   byte_item_type     expected_bytes[$];
   logic [BYTE_W-1:0] run_bytes[$];
   code_item_type     next_code;
   byte_item_type     want;

   logic [CODE_W-1:0] dict_prefix[DICT_DEPTH];
   logic [BYTE_W-1:0] dict_tail[DICT_DEPTH];
   logic [BYTE_W-1:0] dict_first[DICT_DEPTH];
   logic [LEN_W-1:0]  dict_len[DICT_DEPTH];
   int                free_code = FIRST_CODE;
   logic [CODE_W-1:0] last_code = '0;
   logic              last_present = 1'b0;
   logic              last_has_tail = 1'b0;
   logic [BYTE_W-1:0] last_tail = '0;

   int                plan_free = FIRST_CODE;
   logic              plan_present = 1'b0;
   logic              plan_tail = 1'b0;

   int                error_count = 0;
   int                idle_cycles = 0;
   int                cycle_count = 0;
   logic              quiet;

   lzw_code_decoder u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_code       (req_code),
      .req_block_last (req_block_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_bad_code   (rsp_bad_code)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   assign quiet = (cycle_count >= 2000) && (cycle_count < 3500);

   task automatic report(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("MISMATCH: %s", msg);
      end
      error_count++;
   endtask

   // Writes the string of a defined code into run_bytes, first byte first.
   function automatic void spell(input logic [CODE_W-1:0] c);
      logic [CODE_W-1:0] link;
      link = c;
      run_bytes.delete();
      while (link >= FIRST_CODE) begin
         run_bytes.push_front(dict_tail[link - FIRST_CODE]);
         link = dict_prefix[link - FIRST_CODE];
      end
      run_bytes.push_front(link[BYTE_W-1:0]);
   endfunction

   function automatic logic [BYTE_W-1:0] first_byte_of(input logic [CODE_W-1:0] c);
      if (c < FIRST_CODE) begin
         return c[BYTE_W-1:0];
      end
      return dict_first[c - FIRST_CODE];
   endfunction

   function automatic logic [LEN_W-1:0] length_of(input logic [CODE_W-1:0] c);
      if (c < FIRST_CODE) begin
         return LEN_W'(1);
      end
      return dict_len[c - FIRST_CODE];
   endfunction

   function automatic logic add_entry(input logic [BYTE_W-1:0] b);
      int slot;
      if (!last_present || last_has_tail || free_code > LAST_CODE) begin
         return 1'b0;
      end
      slot = free_code - FIRST_CODE;
      dict_prefix[slot] = last_code;
      dict_tail[slot] = b;
      dict_first[slot] = first_byte_of(last_code);
      dict_len[slot] = length_of(last_code) + LEN_W'(1);
      free_code++;
      return 1'b1;
   endfunction

   function automatic void push_single(input logic bad);
      byte_item_type r;
      r = '{data: '0, byte_ok: 1'b0, run_end: 1'b1, bad: bad};
      expected_bytes.push_back(r);
   endfunction

   // Works out the result items of one accepted item and updates the dictionary.
   function automatic void decode_item(input logic kind, input logic [CODE_W-1:0] code,
                                       input logic blk_last);
      logic [BYTE_W-1:0] f;
      byte_item_type     r;
      int                count;
      if (kind == KIND_CLEAR) begin
         free_code = FIRST_CODE;
         last_present = 1'b0;
         last_has_tail = 1'b0;
         last_code = '0;
         last_tail = '0;
         push_single(1'b0);
         return;
      end
      if (code < free_code) begin
         spell(code);
         f = run_bytes[0];
         void'(add_entry(f));
         last_code = code;
         last_present = 1'b1;
         last_has_tail = 1'b0;
         last_tail = '0;
      end else if (!last_present) begin
         if (blk_last) begin
            last_has_tail = 1'b0;
            last_tail = '0;
         end
         push_single(1'b1);
         return;
      end else begin
         f = first_byte_of(last_code);
         spell(last_code);
         if (last_has_tail) begin
            run_bytes.push_back(last_tail);
         end
         run_bytes.push_back(f);
         if (add_entry(f)) begin
            last_code = CODE_W'(free_code - 1);
            last_has_tail = 1'b0;
            last_tail = '0;
         end else if (!last_has_tail) begin
            last_has_tail = 1'b1;
            last_tail = f;
         end
      end
      count = (run_bytes.size() < MAX_STRING) ? run_bytes.size() : MAX_STRING;
      for (int k = 0; k < count; k++) begin
         r = '{data: run_bytes[k], byte_ok: 1'b1, run_end: (k == count - 1), bad: 1'b0};
         expected_bytes.push_back(r);
      end
      if (blk_last) begin
         last_present = 1'b0;
         last_has_tail = 1'b0;
         last_tail = '0;
      end
   endfunction

   // Queues one item and tracks just enough of the dictionary to shape the
   // stimulus: the next free code and whether a previous string exists.
   function automatic void plan(input logic kind, input logic [CODE_W-1:0] code,
                                input logic blk_last);
      code_item_type it;
      it = '{kind: kind, code: code, blk_last: blk_last};
      pending_codes.push_back(it);
      if (kind == KIND_CLEAR) begin
         plan_free = FIRST_CODE;
         plan_present = 1'b0;
         plan_tail = 1'b0;
      end else begin
         if (code < plan_free) begin
            if (plan_present && !plan_tail && plan_free <= LAST_CODE) begin
               plan_free++;
            end
            plan_present = 1'b1;
            plan_tail = 1'b0;
         end else if (plan_present) begin
            if (!plan_tail && plan_free <= LAST_CODE) begin
               plan_free++;
            end else begin
               plan_tail = 1'b1;
            end
         end
         if (blk_last) begin
            plan_present = 1'b0;
            plan_tail = 1'b0;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_item(req_kind, req_code, req_block_last);
         end
         if (!req_valid || !req_stall) begin
            if (pending_codes.size() != 0 &&
                (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
               next_code = pending_codes.pop_front();
               req_valid <= 1'b1;
               req_kind <= next_code.kind;
               req_code <= next_code.code;
               req_block_last <= next_code.blk_last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               report("result item arrived with nothing expected");
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.data) begin
                  report($sformatf("out_byte %h, expected %h", rsp_out_byte, want.data));
               end
               if (rsp_byte_valid !== want.byte_ok) begin
                  report($sformatf("byte_valid %b, expected %b", rsp_byte_valid,
                                   want.byte_ok));
               end
               if (rsp_run_last !== want.run_end) begin
                  report($sformatf("run_last %b, expected %b", rsp_run_last, want.run_end));
               end
               if (rsp_bad_code !== want.bad) begin
                  report($sformatf("bad_code %b, expected %b", rsp_bad_code, want.bad));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic blk;
      int   r;

      // Directed opening: errors, clears, literal extremes and short strings.
      plan(KIND_DECODE, 9'd511, 1'b1);
      plan(KIND_DECODE, 9'd256, 1'b0);
      plan(KIND_CLEAR, 9'd511, 1'b1);
      plan(KIND_DECODE, 9'd0, 1'b0);
      plan(KIND_DECODE, 9'd255, 1'b0);
      plan(KIND_DECODE, 9'd256, 1'b0);
      plan(KIND_DECODE, 9'd258, 1'b0);
      plan(KIND_DECODE, 9'd258, 1'b0);
      plan(KIND_DECODE, 9'd511, 1'b0);
      plan(KIND_DECODE, 9'h05A, 1'b1);
      plan(KIND_DECODE, 9'd300, 1'b0);
      plan(KIND_DECODE, 9'h0A5, 1'b0);
      plan(KIND_DECODE, 9'd257, 1'b1);
      plan(KIND_CLEAR, 9'd0, 1'b0);
      plan(KIND_DECODE, 9'd256, 1'b0);

      // Fill the dictionary with one ever-longer string, then run it past
      // the longest string and saturate the tail of the previous string.
      plan(KIND_CLEAR, CODE_W'($urandom_range(511)), 1'($urandom_range(1)));
      plan(KIND_DECODE, CODE_W'($urandom_range(255)), 1'b0);
      while (plan_free <= LAST_CODE) begin
         plan(KIND_DECODE, CODE_W'(plan_free), 1'b0);
      end
      plan(KIND_DECODE, CODE_W'($urandom_range(511, LAST_CODE + 1)), 1'b0);
      plan(KIND_DECODE, CODE_W'($urandom_range(511, LAST_CODE + 1)), 1'b0);
      plan(KIND_DECODE, CODE_W'($urandom_range(LAST_CODE, FIRST_CODE)), 1'b0);
      plan(KIND_DECODE, CODE_W'($urandom_range(511, LAST_CODE + 1)), 1'b1);

      // Mostly well-formed code streams with random content, some noise.
      for (int i = 0; i < 37; i++) begin
         r = $urandom_range(99);
         blk = ($urandom_range(99) < 8);
         if (r < 3) begin
            plan(KIND_CLEAR, CODE_W'($urandom_range(511)), 1'($urandom_range(1)));
         end else if (r < 10) begin
            plan(KIND_DECODE, CODE_W'($urandom_range(511)), blk);
         end else if (r < 45 || plan_free == FIRST_CODE) begin
            plan(KIND_DECODE, CODE_W'($urandom_range(255)), blk);
         end else if (r < 75) begin
            plan(KIND_DECODE, CODE_W'($urandom_range(plan_free - 1, FIRST_CODE)), blk);
         end else begin
            plan(KIND_DECODE, CODE_W'($urandom_range(511, plan_free)), blk);
         end
      end

      while (reset) begin
         @(posedge clock);
      end
      while (pending_codes.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         report("expected result items left over at the end");
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
